// ----- hw/rtl/rabx_pkg.sv -----
package rabx_pkg;

  localparam int CFG_W = 17;
  localparam int ACC_W = 48;

  typedef enum logic [2:0] {
    REG_RISE,
    REG_FALL,
    REG_PROB,
    REG_MODE,
    REG_SCALE_A,
    REG_SCALE_B,
    REG_OFFSET_A,
    REG_OFFSET_B
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROB,
    ST_CTRL,
    ST_XA,
    ST_XB,
    ST_AO,
    ST_AO2,
    ST_BO,
    ST_BO2,
    ST_DONE
  } state_t;

  localparam logic [1:0] MODE_TOGGLE = 2'd0;
  localparam logic [1:0] MODE_SWAP   = 2'd1;
  localparam logic [1:0] MODE_GATE   = 2'd2;

  localparam logic signed [16:0] TEN_VOLTS  = 17'sd10240;
  localparam logic [16:0]        UNITY_GAIN = 17'd32768;
  localparam logic [16:0]        PROB_FULL  = 17'd65536;

  // 32/5 scaled by 2^20, rounded up
  localparam logic [22:0] DIV5_RECIP = 23'd6710887;
  localparam int          DIV5_SHIFT = 20;

endpackage

// ----- hw/rtl/rabx_if.sv -----
interface rabx_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic signed [15:0] trig_level;
  logic               manual_press;
  logic signed [15:0] prob_cv;
  logic signed [15:0] a_level;
  logic               a_patched;
  logic signed [15:0] b_level;
  logic [15:0]        coin;

  modport source (
    output valid, channel, trig_level, manual_press, prob_cv, a_level, a_patched,
           b_level, coin,
    input  ready
  );
  modport sink (
    input  valid, channel, trig_level, manual_press, prob_cv, a_level, a_patched,
           b_level, coin,
    output ready
  );
endinterface

interface rabx_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_result;
  logic signed [15:0] b_result;
  logic               swapped;

  modport source (output valid, a_result, b_result, swapped, input ready);
  modport sink (input valid, a_result, b_result, swapped, output ready);
endinterface

// ----- hw/rtl/random_ab_crossfade_switch.sv -----
// Random A/B crossfade switch, one sample of one channel per request.
// Channels: sample_in carries the trigger, probability CV, coin and the A/B
// inputs of one channel; sample_out returns the crossfaded A/B outputs and
// the channel's swap flag. Both use valid/ready; a request moves on a clock
// edge with valid and ready high. Registers are written over cfg_write,
// cfg_index and cfg_data; the user must do so only while no request is in
// flight, since the block itself does not enforce it. No new request is
// taken until the previous result has moved into the output register; a
// single multiply-accumulate unit runs seven passes per request (probability
// scaling, two input gains, four crossfade products) under a small sequencer.
// A channel number of CHANNELS or above changes no state, skips the gain and
// crossfade passes and returns zeros.
// Reset (rst, synchronous) clears the Schmitt state, swap flags and fade
// gains of every channel and restores the register defaults.
// When the receiver stalls, the finished result waits in the output
// register; the next request is still taken and worked on, and holds in its
// last step until the output register frees.
module random_ab_crossfade_switch #(
  parameter int CHANNELS  = 16,
  parameter int FADE_STEP = 68
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  rabx_pkg::reg_index_t        cfg_index,
  input  logic [rabx_pkg::CFG_W-1:0]  cfg_data,
  rabx_in_if.sink                     sample_in,
  rabx_out_if.source                  sample_out
);
  import rabx_pkg::*;

  localparam int               CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0]       CH_LIM = 5'(CHANNELS);
  localparam logic signed [17:0] STEP = 18'(FADE_STEP);

  // configuration
  logic signed [14:0] rise_level, fall_level, offset_a, offset_b;
  logic [16:0]        prob_bias;
  logic [3:0]         mode_bits;
  logic signed [15:0] scale_a, scale_b;

  // latched request
  logic [3:0]         ch;
  logic signed [15:0] trig, pcv, a_lvl, b_lvl;
  logic               manual, a_patch;
  logic [15:0]        coin;

  // per-channel state
  logic               trig_hi [CHANNELS];
  logic               swap_fl [CHANNELS];
  logic [15:0]        gain    [CHANNELS];

  state_t state, state_next;

  logic signed [ACC_W-1:0] acc, acc_next, mac_base;
  logic signed [31:0]      mac_a;
  logic signed [23:0]      mac_b;
  logic signed [55:0]      mac_prod;
  logic                    mac_en;

  logic [15:0]        g;
  logic               sw;
  logic signed [15:0] a_sel;
  logic signed [31:0] xa, xb;
  logic signed [15:0] ao;

  logic               out_valid, out_load;
  logic signed [15:0] out_a, out_b;
  logic               out_sw;

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = (x + 48'sd268435456) >>> 29;
    if (y > 48'sd32767) return 16'sh7fff;
    if (y < -48'sd32768) return -16'sh8000;
    return y[15:0];
  endfunction

  // control-step signals
  logic               ch_ok;
  logic [CH_W-1:0]    idx;
  logic signed [16:0] t_sum, tv;
  logic signed [15:0] t_sat, hi, lo, norm;
  logic               inv;
  logic [15:0]        pcv_mag;
  logic [17:0]        q_mag;
  logic signed [19:0] q_s, prob_sum;
  logic [16:0]        prob_sat;
  logic               toss;
  logic               th_new, sw_new;
  logic signed [17:0] cur, target;
  logic [15:0]        g_new;
  logic [16:0]        wa;

  assign ch_ok   = {1'b0, ch} < CH_LIM;
  assign idx     = ch[CH_W-1:0];
  assign pcv_mag = pcv[15] ? 16'(-pcv) : 16'(pcv);
  assign wa      = UNITY_GAIN - {1'b0, g};

  always_comb begin
    t_sum = {trig[15], trig} + (manual ? TEN_VOLTS : 17'sd0);
    if (t_sum > 17'sd32767) t_sat = 16'sh7fff;
    else if (t_sum < -17'sd32768) t_sat = -16'sh8000;
    else t_sat = t_sum[15:0];

    inv = rise_level < fall_level;
    hi  = inv ? -{rise_level[14], rise_level} : {rise_level[14], rise_level};
    lo  = inv ? -{fall_level[14], fall_level} : {fall_level[14], fall_level};
    tv  = inv ? -{t_sat[15], t_sat} : {t_sat[15], t_sat};

    q_mag    = acc[DIV5_SHIFT+17:DIV5_SHIFT];
    q_s      = pcv[15] ? -{2'b00, q_mag} : {2'b00, q_mag};
    prob_sum = $signed({3'b000, prob_bias}) + q_s;
    if (prob_sum < 20'sd0) prob_sat = '0;
    else if (prob_sum > $signed({3'b000, PROB_FULL})) prob_sat = PROB_FULL;
    else prob_sat = prob_sum[16:0];
    toss = {1'b0, coin} < prob_sat;

    th_new = trig_hi[idx];
    sw_new = swap_fl[idx];
    if (trig_hi[idx]) begin
      if (tv <= $signed({lo[15], lo})) th_new = 1'b0;
    end else if (tv >= $signed({hi[15], hi})) begin
      th_new = 1'b1;
      case (mode_bits[1:0])
        MODE_TOGGLE: if (toss) sw_new = !swap_fl[idx];
        MODE_SWAP:   sw_new = toss;
        MODE_GATE:   sw_new = !toss;
        default:     ;
      endcase
    end
    if (mode_bits[1:0] == MODE_GATE && !sw_new && !th_new) sw_new = 1'b1;

    cur    = {2'b00, gain[idx]};
    target = sw_new ? $signed({1'b0, UNITY_GAIN}) : 18'sd0;
    if (mode_bits[3]) begin
      if (target > cur + STEP) cur = cur + STEP;
      else if (target < cur - STEP) cur = cur - STEP;
      else cur = target;
    end else begin
      cur = target;
    end
    g_new = cur[15:0];

    if (mode_bits[2]) norm = th_new ? (inv ? -16'sd10240 : 16'sd10240) : 16'sd0;
    else norm = t_sat;
  end

  // shared multiply-accumulate
  assign mac_prod = mac_a * mac_b;
  assign acc_next = mac_base + mac_prod[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (sample_in.valid) state_next = ST_PROB;
      ST_PROB: state_next = ST_CTRL;
      ST_CTRL: state_next = ch_ok ? ST_XA : ST_DONE;
      ST_XA:   state_next = ST_XB;
      ST_XB:   state_next = ST_AO;
      ST_AO:   state_next = ST_AO2;
      ST_AO2:  state_next = ST_BO;
      ST_BO:   state_next = ST_BO2;
      ST_BO2:  state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_in.ready = 1'b0;
    out_load        = 1'b0;
    mac_en          = 1'b0;
    mac_a           = '0;
    mac_b           = '0;
    mac_base        = '0;
    case (state)
      ST_IDLE: sample_in.ready = 1'b1;
      ST_PROB: begin
        mac_en = 1'b1;
        mac_a  = {16'b0, pcv_mag};
        mac_b  = {1'b0, DIV5_RECIP};
      end
      ST_XA: begin
        mac_en   = 1'b1;
        mac_a    = {{16{a_sel[15]}}, a_sel};
        mac_b    = {{8{scale_a[15]}}, scale_a};
        mac_base = {{19{offset_a[14]}}, offset_a, 14'b0};
      end
      ST_XB: begin
        mac_en   = 1'b1;
        mac_a    = {{16{b_lvl[15]}}, b_lvl};
        mac_b    = {{8{scale_b[15]}}, scale_b};
        mac_base = {{19{offset_b[14]}}, offset_b, 14'b0};
      end
      ST_AO: begin
        mac_en = 1'b1;
        mac_a  = xa;
        mac_b  = {7'b0, wa};
      end
      ST_AO2: begin
        mac_en   = 1'b1;
        mac_a    = xb;
        mac_b    = {8'b0, g};
        mac_base = acc;
      end
      ST_BO: begin
        mac_en = 1'b1;
        mac_a  = xb;
        mac_b  = {7'b0, wa};
      end
      ST_BO2: begin
        mac_en   = 1'b1;
        mac_a    = xa;
        mac_b    = {8'b0, g};
        mac_base = acc;
      end
      ST_DONE: out_load = !out_valid || sample_out.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_level <= 15'sd1024;
      fall_level <= 15'sd102;
      prob_bias  <= 17'd32768;
      mode_bits  <= 4'd1;
      scale_a    <= 16'sd16384;
      scale_b    <= 16'sd16384;
      offset_a   <= '0;
      offset_b   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RISE:     rise_level <= cfg_data[14:0];
        REG_FALL:     fall_level <= cfg_data[14:0];
        REG_PROB:     prob_bias  <= cfg_data[16:0];
        REG_MODE:     mode_bits  <= cfg_data[3:0];
        REG_SCALE_A:  scale_a    <= cfg_data[15:0];
        REG_SCALE_B:  scale_b    <= cfg_data[15:0];
        REG_OFFSET_A: offset_a   <= cfg_data[14:0];
        REG_OFFSET_B: offset_b   <= cfg_data[14:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        trig_hi[i] <= 1'b0;
        swap_fl[i] <= 1'b0;
        gain[i]    <= '0;
      end
    end else if (state == ST_CTRL && ch_ok) begin
      trig_hi[idx] <= th_new;
      swap_fl[idx] <= sw_new;
      gain[idx]    <= g_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      ch      <= sample_in.channel;
      trig    <= sample_in.trig_level;
      manual  <= sample_in.manual_press;
      pcv     <= sample_in.prob_cv;
      a_lvl   <= sample_in.a_level;
      a_patch <= sample_in.a_patched;
      b_lvl   <= sample_in.b_level;
      coin    <= sample_in.coin;
    end
    if (mac_en) acc <= acc_next;
    if (state == ST_CTRL) begin
      g     <= g_new;
      sw    <= sw_new;
      a_sel <= a_patch ? a_lvl : norm;
    end
    if (state == ST_XB) xa <= acc[31:0];
    if (state == ST_AO) xb <= acc[31:0];
    if (state == ST_BO) ao <= round_sat(acc);
    if (out_load) begin
      out_a  <= ch_ok ? ao : 16'sd0;
      out_b  <= ch_ok ? round_sat(acc) : 16'sd0;
      out_sw <= ch_ok && sw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (sample_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sample_out.valid    = out_valid;
  assign sample_out.a_result = out_a;
  assign sample_out.b_result = out_b;
  assign sample_out.swapped  = out_sw;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("input taken again while a request is in progress");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XA) |-> ({1'b0, g} <= UNITY_GAIN))
    else $error("fade gain beyond unity");

  a_gain_jump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XA && !mode_bits[3]) |-> (g == 16'd0 || g == 16'd32768))
    else $error("gain not at an end point with fade off");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_out.valid) |-> $past(state == ST_DONE))
    else $error("output valid raised outside the final step");

endmodule
